/* src/fwwu_pkg.sv */
// ----------------------------------------------------------------------------
// fwwu_pkg: shared constants and the binomial helper
// Field widths of the unrank block and a Pascal-row function that is
// evaluated at elaboration to fill each cell's constant row.
// ----------------------------------------------------------------------------
`default_nettype none

package fwwu_pkg;

	// field widths
	localparam int RANK_W  = 64;
	localparam int LEFT_W  = 6;
	localparam int CFG_W   = 6;
	localparam int WORD_W  = 62;
	localparam int ROW_LEN = 64;

	// reset value of the length register
	localparam logic [CFG_W-1:0] BIT_COUNT_RST = 6'd8;

	// C(n, k) by building Pascal rows additively; 0 when k > n
	function automatic logic [RANK_W-1:0] binom(input int n, input int k);
		logic [RANK_W-1:0] row [ROW_LEN];
		int r;
		int c;
		for (c = 0; c < ROW_LEN; c++) begin
			row[c] = '0;
		end
		row[0] = 64'd1;
		for (r = 1; r <= n; r++) begin
			for (c = r; c >= 1; c--) begin
				row[c] = row[c] + row[c-1];
			end
		end
		if (k < 0 || k >= ROW_LEN || n < 0 || n >= ROW_LEN) begin
			binom = '0;
		end else begin
			binom = row[k];
		end
	endfunction

endpackage

`default_nettype wire

/* src/fixed_weight_word_unrank.sv */
// ----------------------------------------------------------------------------
// fixed_weight_word_unrank: rank to fixed-weight word
// Produces the rank-th word of bit_count bits with exactly ones_wanted
// ones, scanning from bit 0 upward through a chain of binomial cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | sink      | in_valid / in_ready    | ones_wanted, rank_value
//  out     | source    | out_valid / out_ready  | word_out, status
//  cfg     | sink      | cfg_valid / cfg_ready  | bit_count
//
//  One request enters per cycle while in_ready is high; on its way to the
//  output it passes one cell per bit position, then the output register.
//  Each stage holds its request unless the stage after it is empty or
//  moving, so bubbles close up and requests keep entering while a result
//  waits at the output. cfg_ready is always high.
//  Reset empties every stage and sets bit_count to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_weight_word_unrank #(
	parameter int MAX_BITS = 62
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [fwwu_pkg::LEFT_W-1:0] ones_wanted,
	input  wire logic [fwwu_pkg::RANK_W-1:0] rank_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [fwwu_pkg::WORD_W-1:0]      word_out,
	output logic                             status,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [fwwu_pkg::CFG_W-1:0]  bit_count
);
	import fwwu_pkg::*;

	logic [CFG_W-1:0]  bit_count_q;
	logic [CFG_W-1:0]  n_eff;
	logic [CFG_W-1:0]  shift_amt;

	// stage 0 is the input port, stage MAX_BITS the last cell
	logic              st_valid [MAX_BITS+1];
	logic [RANK_W-1:0] st_rank  [MAX_BITS+1];
	logic [LEFT_W-1:0] st_left  [MAX_BITS+1];
	logic [MAX_BITS-1:0] st_bits [MAX_BITS+1];
	logic              load     [MAX_BITS+1];

	logic [MAX_BITS-1:0] rev_bits;
	logic [MAX_BITS-1:0] shifted;
	logic                ok;
	logic                out_valid_q;
	logic [WORD_W-1:0]   word_q;
	logic                status_q;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= BIT_COUNT_RST;
		end else if (cfg_valid) begin
			bit_count_q <= bit_count;
		end
	end
	assign cfg_ready = 1'b1;

	// length saturates at MAX_BITS
	assign n_eff = (bit_count_q > CFG_W'(MAX_BITS)) ? CFG_W'(MAX_BITS) : bit_count_q;

	// input feeds stage 0
	assign st_valid[0] = in_valid;
	assign st_rank[0]  = rank_value;
	assign st_left[0]  = ones_wanted;
	assign st_bits[0]  = '0;

	// a stage loads when it is empty or its content moves on
	assign load[MAX_BITS] = !out_valid_q || out_ready;
	for (genvar i = 0; i < MAX_BITS; i++) begin : g_load
		assign load[i] = !st_valid[i+1] || load[i+1];
	end
	assign in_ready = load[0];

	// cell chain, highest position count first
	for (genvar j = 0; j < MAX_BITS; j++) begin : g_cell
		fwwu_cell #(
			.M        (MAX_BITS - 1 - j),
			.MAX_BITS (MAX_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (load[j]),
			.prev_valid (st_valid[j]),
			.prev_rank  (st_rank[j]),
			.prev_left  (st_left[j]),
			.prev_bits  (st_bits[j]),
			.n_eff      (n_eff),
			.valid_q    (st_valid[j+1]),
			.rank_q     (st_rank[j+1]),
			.left_q     (st_left[j+1]),
			.bits_q     (st_bits[j+1])
		);
	end

	// bits are kept by position count; reverse and align to bit 0
	for (genvar b = 0; b < MAX_BITS; b++) begin : g_rev
		assign rev_bits[b] = st_bits[MAX_BITS][MAX_BITS-1-b];
	end
	assign shift_amt = CFG_W'(MAX_BITS) - n_eff;
	assign shifted   = rev_bits >> shift_amt;

	// rank in range exactly when the scan used up both rank and ones
	assign ok = (st_rank[MAX_BITS] == '0) && (st_left[MAX_BITS] == '0);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load[MAX_BITS]) begin
			out_valid_q <= st_valid[MAX_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (load[MAX_BITS]) begin
			word_q   <= ok ? WORD_W'(shifted) : '0;
			status_q <= !ok;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = word_q;
	assign status    = status_q;

endmodule

`default_nettype wire

/* src/fwwu_cell.sv */
// ----------------------------------------------------------------------------
// fwwu_cell: one compare-subtract cell of the unrank chain
// Handles the bit whose count of lower positions is M. Looks up
// C(M, ones left) in a constant row, subtracts it when the rank allows
// and records the bit in the word-in-progress.
// ----------------------------------------------------------------------------
`default_nettype none

module fwwu_cell #(
	parameter int M        = 0,
	parameter int MAX_BITS = 62
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic                        prev_valid,
	input  wire logic [fwwu_pkg::RANK_W-1:0] prev_rank,
	input  wire logic [fwwu_pkg::LEFT_W-1:0] prev_left,
	input  wire logic [MAX_BITS-1:0]         prev_bits,
	input  wire logic [fwwu_pkg::CFG_W-1:0]  n_eff,
	output logic                             valid_q,
	output logic [fwwu_pkg::RANK_W-1:0]      rank_q,
	output logic [fwwu_pkg::LEFT_W-1:0]      left_q,
	output logic [MAX_BITS-1:0]              bits_q
);
	import fwwu_pkg::*;

	logic [RANK_W-1:0]   row_c [ROW_LEN];
	logic [RANK_W-1:0]   coef;
	logic                active;
	logic                take;
	logic [MAX_BITS-1:0] set_mask;

	// constant Pascal row for this cell
	for (genvar k = 0; k < ROW_LEN; k++) begin : g_row
		assign row_c[k] = binom(M, k);
	end

	// cell is live only inside the configured length and while ones remain
	assign coef   = row_c[prev_left];
	assign active = (CFG_W'(M) < n_eff) && (prev_left != '0);
	assign take   = active && (prev_rank >= coef);

	// bit owned by this cell
	assign set_mask = MAX_BITS'(1) << M;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			rank_q <= take ? (prev_rank - coef) : prev_rank;
			left_q <= take ? (prev_left - LEFT_W'(1)) : prev_left;
			bits_q <= take ? (prev_bits | set_mask) : prev_bits;
		end
	end

endmodule

`default_nettype wire

/* src/fwwu_chk.sv */
// ----------------------------------------------------------------------------
// fwwu_chk: port checker for the unrank block
// Watches the top-level ports for output hold, error encoding, input
// readiness and request/result accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module fwwu_chk #(
	parameter int MAX_BITS = 62
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [fwwu_pkg::WORD_W-1:0] word_out,
	input  wire logic                        status
);
	import fwwu_pkg::*;

	localparam int CNT_W = $clog2(MAX_BITS + 3);

	logic [CNT_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_out) && $stable(status))
		else $error("result changed while stalled");

	// errors carry an all-zero word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> word_out == '0)
		else $error("error result with nonzero word");

	// free output slot means the chain can take a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with output free");

	// no result without a request behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result with no outstanding request");

	// occupancy bounded by the chain depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(MAX_BITS + 1))
		else $error("more requests in flight than stages");

endmodule

bind fixed_weight_word_unrank fwwu_chk #(
	.MAX_BITS (MAX_BITS)
) u_fwwu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.word_out  (word_out),
	.status    (status)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fixed_weight_word_unrank
// Drives (weight, rank) requests through valid/ready, predicts each word
// from a local Pascal table and compares results in order. A directed table
// covers the class edges and length extremes; random phases at several
// lengths follow, with random idling on both sides, one long output
// hold-off and drains before every length change.
// ----------------------------------------------------------------------------
module tb;
	import fwwu_pkg::*;

	localparam int LEN_MAX      = 62;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = LEN_MAX + 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 50;
	localparam int HOLD_ITEMS   = 80;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOC = 1'b1;   // rank outside class

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              status;
	} word_result_t;

	typedef enum logic {ROW_SET_LEN, ROW_UNRANK} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CFG_W-1:0]  len;
		logic [LEFT_W-1:0] ones;
		logic [RANK_W-1:0] rank;
		bit                typed;
		word_result_t      res;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [LEFT_W-1:0]   ones_wanted;
	logic [RANK_W-1:0]   rank_value;
	logic                out_valid;
	logic                out_ready;
	logic [WORD_W-1:0]   word_out;
	logic                status;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    bit_count;

	logic [RANK_W-1:0]   pascal [0:LEN_MAX][0:LEN_MAX];
	logic [CFG_W-1:0]    len_reg;
	word_result_t        pending_words [$];
	plan_row_t           plan [$];
	int                  mismatches;
	bit                  steady;
	bit                  hold_req;

	fixed_weight_word_unrank #(.MAX_BITS(LEN_MAX)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ones_wanted(ones_wanted),
		.rank_value (rank_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_out   (word_out),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.bit_count  (bit_count)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL fixed_weight_word_unrank");
		$finish;
	end

	// C(n, k), zero when k > n
	function automatic logic [RANK_W-1:0] binomial(input int n, input int k);
		if (n < 0 || k < 0 || n > LEN_MAX || k > n) begin
			return '0;
		end
		return pascal[n][k];
	endfunction

	// word predictor: scan from bit 0 up, subtracting binomials
	function automatic word_result_t unrank(input logic [CFG_W-1:0] len_cfg,
			input logic [LEFT_W-1:0] w, input logic [RANK_W-1:0] r);
		word_result_t      res;
		int                n;
		int                left;
		int                p;
		logic [RANK_W-1:0] rem;
		logic [RANK_W-1:0] c;
		n          = (len_cfg > LEN_MAX) ? LEN_MAX : int'(len_cfg);
		left       = int'(w);
		rem        = r;
		res.word   = '0;
		res.status = STATUS_OK;
		if (rem >= binomial(n, left)) begin
			res.status = STATUS_OOC;
			return res;
		end
		for (p = 0; p < n && left != 0; p++) begin
			c = binomial(n - p - 1, left);
			if (rem >= c) begin
				rem         = rem - c;
				res.word[p] = 1'b1;
				left--;
			end
		end
		return res;
	endfunction

	// directed table helpers
	function automatic void plan_len(input logic [CFG_W-1:0] v);
		plan_row_t row;
		row.kind  = ROW_SET_LEN;
		row.len   = v;
		row.ones  = '0;
		row.rank  = '0;
		row.typed = 1'b0;
		row.res   = '0;
		plan      = {plan, row};
	endfunction

	function automatic void plan_req(input logic [LEFT_W-1:0] w, input logic [RANK_W-1:0] r,
			input bit typed, input logic [WORD_W-1:0] word, input logic st);
		plan_row_t row;
		row.kind       = ROW_UNRANK;
		row.len        = '0;
		row.ones       = w;
		row.rank       = r;
		row.typed      = typed;
		row.res.word   = word;
		row.res.status = st;
		plan           = {plan, row};
	endfunction

	// random request: mostly inside the class, some noise and class edges
	function automatic void pick_request(output logic [LEFT_W-1:0] w,
			output logic [RANK_W-1:0] r);
		int                n;
		int                roll;
		logic [RANK_W-1:0] c;
		n    = (len_reg > LEN_MAX) ? LEN_MAX : int'(len_reg);
		roll = $urandom_range(0, 99);
		if (roll < 85) begin
			w = LEFT_W'($urandom_range(0, n));
			c = binomial(n, int'(w));
			if (roll < 8) begin
				r = c - 1;
			end else if (roll < 16) begin
				r = '0;
			end else begin
				r = {$urandom, $urandom} % c;
			end
		end else begin
			w = LEFT_W'($urandom_range(0, 63));
			if (roll < 93) begin
				r = binomial(n, int'(w)) + RANK_W'($urandom_range(0, 3));
			end else begin
				r = {$urandom, $urandom};
			end
		end
	endfunction

	// present one request; entered and left at a falling edge
	task automatic send_request(input logic [LEFT_W-1:0] w, input logic [RANK_W-1:0] r,
			input bit typed, input word_result_t typed_res);
		word_result_t exp_res;
		while (!steady && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		ones_wanted <= w;
		rank_value  <= r;
		do @(posedge clk); while (!in_ready);
		exp_res       = typed ? typed_res : unrank(len_reg, w, r);
		pending_words = {pending_words, exp_res};
		@(negedge clk);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		bit_count <= v;
		do @(posedge clk); while (!cfg_ready);
		len_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output side: random stalls, steady stretch, one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 36);
			end
		end
	end

	// in-order result check
	always @(posedge clk) begin : check_results
		word_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word=%h status=%0b",
					$time, word_out, status);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (word_out !== want.word) begin
					$display("%0t: word_out expected %h actual %h",
						$time, want.word, word_out);
					mismatches++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0b actual %0b",
						$time, want.status, status);
					mismatches++;
				end
			end
		end
	end

	// main sequence
	initial begin : main_seq
		logic [LEFT_W-1:0] w;
		logic [RANK_W-1:0] r;
		logic [CFG_W-1:0]  phase_len [PHASES];
		word_result_t      none;
		int                i;
		int                k;
		int                rr;
		int                cc;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		ones_wanted = '0;
		rank_value  = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		bit_count   = BIT_COUNT_RST;
		len_reg     = BIT_COUNT_RST;
		mismatches  = 0;
		steady      = 1'b0;
		hold_req    = 1'b0;
		none        = '0;

		// Pascal triangle
		for (rr = 0; rr <= LEN_MAX; rr++) begin
			for (cc = 0; cc <= LEN_MAX; cc++) begin
				if (cc == 0) begin
					pascal[rr][cc] = 1;
				end else if (rr == 0) begin
					pascal[rr][cc] = '0;
				end else begin
					pascal[rr][cc] = pascal[rr-1][cc-1] + pascal[rr-1][cc];
				end
			end
		end

		// directed table; length starts at its reset value of 8
		plan_req(0, 0, 1, '0, STATUS_OK);
		plan_req(0, 1, 1, '0, STATUS_OOC);
		plan_req(8, 0, 1, WORD_W'(8'hFF), STATUS_OK);
		plan_req(9, 0, 1, '0, STATUS_OOC);           // weight above length
		plan_req(63, '1, 1, '0, STATUS_OOC);
		plan_req(1, 0, 0, '0, STATUS_OK);
		plan_req(4, 69, 0, '0, STATUS_OK);            // last rank of C(8,4)
		plan_req(4, 70, 1, '0, STATUS_OOC);
		plan_req(4, '1, 1, '0, STATUS_OOC);
		plan_len(62);
		plan_req(62, 0, 1, '1, STATUS_OK);
		plan_req(31, binomial(62, 31) - 1, 0, '0, STATUS_OK);
		plan_req(31, binomial(62, 31), 1, '0, STATUS_OOC);
		plan_req(1, 61, 0, '0, STATUS_OK);
		plan_req(30, 64'h0123_4567_89AB_CDEF, 0, '0, STATUS_OK);
		plan_len(63);                                 // saturates to 62
		plan_req(62, 0, 1, '1, STATUS_OK);
		plan_req(63, 0, 1, '0, STATUS_OOC);
		plan_len(0);                                  // empty word length
		plan_req(0, 0, 1, '0, STATUS_OK);
		plan_req(0, 1, 1, '0, STATUS_OOC);
		plan_req(1, 0, 1, '0, STATUS_OOC);
		plan_len(1);
		plan_req(1, 0, 1, WORD_W'(1), STATUS_OK);
		plan_req(0, 0, 1, '0, STATUS_OK);
		plan_req(1, 1, 1, '0, STATUS_OOC);
		plan_req(2, 0, 1, '0, STATUS_OOC);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_SET_LEN) begin
				drain_requests();
				write_length(plan[i].len);
			end else begin
				send_request(plan[i].ones, plan[i].rank, plan[i].typed, plan[i].res);
			end
		end

		// random phases, one length setting each
		phase_len[0] = 62;
		phase_len[1] = 63;
		phase_len[2] = 1;
		phase_len[3] = 0;
		for (k = 4; k < PHASES; k++) begin
			phase_len[k] = CFG_W'($urandom_range(2, 61));
		end

		for (k = 0; k < PHASES; k++) begin
			drain_requests();
			write_length(phase_len[k]);
			steady = (k == 5);
			// first phase: output held off long enough to back up the input
			if (k == 0) begin
				hold_req = 1'b1;
			end
			for (i = 0; i < ((k == 0) ? HOLD_ITEMS : PHASE_ITEMS); i++) begin
				pick_request(w, r);
				send_request(w, r, 0, none);
			end
		end
		steady = 1'b0;

		drain_requests();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS fixed_weight_word_unrank");
		end else begin
			$display("FAIL fixed_weight_word_unrank");
		end
		$finish;
	end

endmodule

/* sim.f */
src/fwwu_pkg.sv
src/fwwu_cell.sv
src/fixed_weight_word_unrank.sv
src/fwwu_chk.sv
tb/tb.sv
